### rtl/core/jtl_pkg.sv
`default_nettype none
package jtl_pkg;

    // lexer modes
    typedef enum logic [2:0] {
        M_START    = 3'd0,
        M_STRING   = 3'd1,
        M_ESCAPE   = 3'd2,
        M_UNICODE  = 3'd3,
        M_INTEGER  = 3'd4,
        M_FRACTION = 3'd5,
        M_EXPONENT = 3'd6,
        M_WORD     = 3'd7
    } t_mode;

    // result kinds
    localparam logic [1:0] K_BYTE  = 2'd0;
    localparam logic [1:0] K_TOKEN = 2'd1;
    localparam logic [1:0] K_ERROR = 2'd2;

    // token types
    localparam logic [3:0] T_EOF    = 4'd0;
    localparam logic [3:0] T_STRING = 4'd1;
    localparam logic [3:0] T_NUMBER = 4'd2;
    localparam logic [3:0] T_TRUE   = 4'd3;
    localparam logic [3:0] T_NULL   = 4'd5;
    localparam logic [3:0] T_LBRACK = 4'd6;
    localparam logic [3:0] T_RBRACK = 4'd7;
    localparam logic [3:0] T_COMMA  = 4'd8;
    localparam logic [3:0] T_LBRACE = 4'd9;
    localparam logic [3:0] T_RBRACE = 4'd10;
    localparam logic [3:0] T_COLON  = 4'd11;

    // error codes
    localparam logic [4:0] E_DECODE     = 5'd0;
    localparam logic [4:0] E_BAD_CHAR   = 5'd1;
    localparam logic [4:0] E_CP_LOW     = 5'd2;
    localparam logic [4:0] E_CP_HIGH    = 5'd3;
    localparam logic [4:0] E_ESC_MISS   = 5'd4;
    localparam logic [4:0] E_ESC_BAD    = 5'd5;
    localparam logic [4:0] E_UNI_SHORT  = 5'd6;
    localparam logic [4:0] E_HEX_BAD    = 5'd7;
    localparam logic [4:0] E_LEAD_DOT   = 5'd8;
    localparam logic [4:0] E_LEAD_PLUS  = 5'd9;
    localparam logic [4:0] E_LONE_SIGN  = 5'd10;
    localparam logic [4:0] E_LEAD_ZERO  = 5'd11;
    localparam logic [4:0] E_FRAC_EMPTY = 5'd12;
    localparam logic [4:0] E_EXP_SIGN2  = 5'd13;
    localparam logic [4:0] E_EXP_SIGNL  = 5'd14;
    localparam logic [4:0] E_EXP_EMPTY  = 5'd15;
    localparam logic [4:0] E_BAD_WORD   = 5'd16;

    // number flag bits
    localparam int NF_FIRST_ZERO = 0;
    localparam int NF_FRAC       = 1;
    localparam int NF_FRAC_DIGIT = 2;
    localparam int NF_EXP        = 3;
    localparam int NF_EXP_SIGN   = 4;
    localparam int NF_EXP_DIGIT  = 5;

    // characters
    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_FF     = 8'h0C;
    localparam logic [7:0] C_BS     = 8'h08;
    localparam logic [7:0] C_LBRACK = 8'h5B;
    localparam logic [7:0] C_RBRACK = 8'h5D;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;
    localparam logic [7:0] C_COLON  = 8'h3A;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_LC_B   = 8'h62;
    localparam logic [7:0] C_LC_E   = 8'h65;
    localparam logic [7:0] C_UC_E   = 8'h45;
    localparam logic [7:0] C_LC_F   = 8'h66;
    localparam logic [7:0] C_LC_N   = 8'h6E;
    localparam logic [7:0] C_LC_R   = 8'h72;
    localparam logic [7:0] C_LC_T   = 8'h74;
    localparam logic [7:0] C_LC_U   = 8'h75;

    // keyword ids
    localparam logic [1:0] KW_NONE  = 2'd0;
    localparam logic [1:0] KW_TRUE  = 2'd1;
    localparam logic [1:0] KW_FALSE = 2'd2;
    localparam logic [1:0] KW_NULL  = 2'd3;

    localparam logic [20:0] CP_MIN = 21'h000020;
    localparam logic [20:0] CP_MAX = 21'h10FFFF;

    typedef struct packed {
        t_mode        mode;
        logic [23:0]  hex_acc;
        logic [2:0]   hex_slot;
        logic         hex_ok;
        logic [1:0]   int_cnt;
        logic [5:0]   nflags;
        logic [8:0]   sign;
        logic [4:0]   kw;
    } t_lex_state;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value_byte;
        logic [3:0] token_type;
        logic [4:0] error_code;
    } t_res;

    typedef struct packed {
        t_res [7:0] item;
        logic [3:0] cnt;
    } t_rlist;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
        return v;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] kw);
        logic [2:0] n;
        case (kw)
            KW_TRUE:  n = 3'd4;
            KW_FALSE: n = 3'd5;
            KW_NULL:  n = 3'd4;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (kw)
            KW_TRUE: begin
                case (pos)
                    3'd0: ch = 8'h74;
                    3'd1: ch = 8'h72;
                    3'd2: ch = 8'h75;
                    3'd3: ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            end
            KW_FALSE: begin
                case (pos)
                    3'd0: ch = 8'h66;
                    3'd1: ch = 8'h61;
                    3'd2: ch = 8'h6C;
                    3'd3: ch = 8'h73;
                    3'd4: ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            end
            KW_NULL: begin
                case (pos)
                    3'd0: ch = 8'h6E;
                    3'd1: ch = 8'h75;
                    3'd2: ch = 8'h6C;
                    3'd3: ch = 8'h6C;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

### rtl/core/jtl_ifs.sv
`default_nettype none
interface jtl_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] char_bytes;
    logic [2:0]  byte_count;
    logic        end_of_input;
    logic        decode_fault;
    modport source (output valid, char_bytes, byte_count, end_of_input, decode_fault,
                    input ready);
    modport sink   (input valid, char_bytes, byte_count, end_of_input, decode_fault,
                    output ready);
endinterface

interface jtl_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value_byte;
    logic [3:0] token_type;
    logic [4:0] error_code;
    logic       last;
    modport source (output valid, kind, value_byte, token_type, error_code, last,
                    input ready);
    modport sink   (input valid, kind, value_byte, token_type, error_code, last,
                    output ready);
endinterface
`default_nettype wire

### rtl/core/json_token_lexer.sv
// json token lexer: streaming tokenizer, one decoded character per input transfer
//
// i_in  (sink): char_bytes, byte_count, end_of_input, decode_fault per character
// o_out (source): one result per transfer; kind selects value byte, token or error,
//   last marks the final result caused by an input character
//
// each accepted character is lexed combinationally against the current mode; all
// of its results (up to eight) are captured together in a result register and then
// drained one per cycle while the receiver is ready. the first result appears in
// the cycle after the input transfer. a character is accepted every cycle as long
// as the previous one produced no result, or one result that the receiver takes; a
// character with k results holds off input until the last of them is taken.
// a character that yields no result is consumed with no output transfer.
// the next character is taken in the same cycle the last pending result leaves,
// so there is no bubble between items.
// when the receiver stalls, the current result holds and input stops while any
// result is pending.
// reset (synchronous, active low) returns the lexer to start mode and drops any
// pending results.
`default_nettype none
module json_token_lexer (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    jtl_in_if.sink     i_in,
    jtl_out_if.source  o_out
);
    import jtl_pkg::*;

    t_lex_state r_state;
    t_lex_state n_state;
    t_rlist     n_list;
    t_res [7:0] r_res;
    logic [3:0] r_left;
    logic [2:0] r_idx;
    logic       in_fire;
    logic       out_fire;
    t_res       cur;

    // combinational lexer step on the current character
    jtl_step u_step (
        .i_state      (r_state),
        .i_char_bytes (i_in.char_bytes),
        .i_byte_count (i_in.byte_count),
        .i_end        (i_in.end_of_input),
        .i_fault      (i_in.decode_fault),
        .o_state      (n_state),
        .o_list       (n_list)
    );

    // accept when nothing pending, or only the result leaving this cycle
    assign i_in.ready = (r_left == 4'd0) || (r_left == 4'd1 && o_out.ready);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = o_out.valid && o_out.ready;

    assign cur              = r_res[r_idx];
    assign o_out.valid      = (r_left != 4'd0);
    assign o_out.kind       = cur.kind;
    assign o_out.value_byte = cur.value_byte;
    assign o_out.token_type = cur.token_type;
    assign o_out.error_code = cur.error_code;
    assign o_out.last       = (r_left == 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode     <= M_START;
            r_state.hex_acc  <= 24'd0;
            r_state.hex_slot <= 3'd0;
            r_state.hex_ok   <= 1'b1;
            r_state.int_cnt  <= 2'd0;
            r_state.nflags   <= 6'd0;
            r_state.sign     <= 9'd0;
            r_state.kw       <= 5'd0;
            r_left           <= 4'd0;
            r_idx            <= 3'd0;
        end else if (in_fire) begin
            r_state <= n_state;
            r_left  <= n_list.cnt;
            r_idx   <= 3'd0;
        end else if (out_fire) begin
            r_left <= r_left - 4'd1;
            r_idx  <= r_idx + 3'd1;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= n_list.item;
        end
    end

    // input is only taken when the pending results drain this cycle
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && r_left != 4'd0 |-> r_left == 4'd1 && out_fire)
        else $error("input taken over pending results");

    // a drained result without new input lowers the count by one
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && !in_fire |=> r_left == $past(r_left) - 4'd1)
        else $error("result count did not step");

    // count stays within the result register
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 4'd8)
        else $error("result count out of range");

    // a unicode escape never rests with six digits
    a_hex_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.hex_slot <= 3'd5)
        else $error("unicode slot count out of range");

    // integer digit count saturates at two
    a_int_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.int_cnt != 2'd3)
        else $error("integer digit count out of range");

endmodule
`default_nettype wire

### rtl/core/jtl_step.sv
`default_nettype none
module jtl_step (
    input  jtl_pkg::t_lex_state i_state,
    input  logic [31:0]         i_char_bytes,
    input  logic [2:0]          i_byte_count,
    input  logic                i_end,
    input  logic                i_fault,
    output jtl_pkg::t_lex_state o_state,
    output jtl_pkg::t_rlist     o_list
);
    import jtl_pkg::*;

    typedef enum logic [1:0] {CL_CHAR, CL_END, CL_FAULT} t_cls;

    typedef struct packed {
        t_lex_state s;
        t_rlist     l;
    } t_work;

    function automatic t_work put(t_work w, logic [1:0] k, logic [7:0] b,
                                  logic [3:0] t, logic [4:0] e);
        t_work r;
        r = w;
        if (w.l.cnt < 4'd8) begin
            r.l.item[w.l.cnt[2:0]] = '{kind: k, value_byte: b, token_type: t, error_code: e};
            r.l.cnt = w.l.cnt + 4'd1;
        end
        return r;
    endfunction

    function automatic t_work pbyte(t_work w, logic [7:0] b);
        return put(w, K_BYTE, b, 4'd0, 5'd0);
    endfunction

    function automatic t_work ptok(t_work w, logic [3:0] t);
        return put(w, K_TOKEN, 8'd0, t, 5'd0);
    endfunction

    function automatic t_work perr(t_work w, logic [4:0] e);
        return put(w, K_ERROR, 8'd0, 4'd0, e);
    endfunction

    function automatic t_work clear_number(t_work w);
        t_work r;
        r = w;
        r.s.int_cnt = 2'd0;
        r.s.nflags  = 6'd0;
        r.s.sign    = 9'd0;
        return r;
    endfunction

    function automatic t_work reset_hex(t_work w);
        t_work r;
        r = w;
        r.s.hex_acc  = 24'd0;
        r.s.hex_slot = 3'd0;
        r.s.hex_ok   = 1'b1;
        return r;
    endfunction

    function automatic t_work flush_sign(t_work w);
        t_work r;
        r = w;
        if (w.s.sign[8]) r = pbyte(r, w.s.sign[7:0]);
        r.s.sign = 9'd0;
        return r;
    endfunction

    function automatic t_work finish_number(t_work w);
        t_work r;
        r = w;
        if (w.s.nflags[NF_EXP] && !w.s.nflags[NF_EXP_DIGIT]) r = perr(r, E_EXP_EMPTY);
        if (w.s.nflags[NF_FRAC] && !w.s.nflags[NF_FRAC_DIGIT]) r = perr(r, E_FRAC_EMPTY);
        if (w.s.sign[8]) begin
            r = perr(r, E_LONE_SIGN);
            r = pbyte(r, C_ZERO);
        end
        if (w.s.int_cnt >= 2'd2 && w.s.nflags[NF_FIRST_ZERO]) r = perr(r, E_LEAD_ZERO);
        r = ptok(r, T_NUMBER);
        r = clear_number(r);
        r.s.mode = M_START;
        return r;
    endfunction

    function automatic t_work finish_word(t_work w);
        t_work r;
        logic [1:0] k;
        logic [2:0] n;
        r = w;
        k = w.s.kw[4:3];
        n = w.s.kw[2:0];
        if (k != KW_NONE && n == kw_len(k)) begin
            r = ptok(r, T_TRUE + {2'd0, k} - 4'd1);
        end else begin
            r = perr(r, E_BAD_WORD);
            r = ptok(r, T_NULL);
        end
        r.s.kw   = 5'd0;
        r.s.mode = M_START;
        return r;
    endfunction

    function automatic t_work finish_unicode(t_work w);
        t_work r;
        logic [23:0] cp;
        r = w;
        cp = w.s.hex_acc;
        if (w.s.hex_ok) begin
            if (cp < {3'd0, CP_MIN}) r = perr(r, E_CP_LOW);
            else if (cp > {3'd0, CP_MAX}) r = perr(r, E_CP_HIGH);
            else if (cp < 24'h80) r = pbyte(r, cp[7:0]);
            else if (cp < 24'h800) begin
                r = pbyte(r, {3'b110, cp[10:6]});
                r = pbyte(r, {2'b10, cp[5:0]});
            end else if (cp < 24'h10000) begin
                r = pbyte(r, {4'b1110, cp[15:12]});
                r = pbyte(r, {2'b10, cp[11:6]});
                r = pbyte(r, {2'b10, cp[5:0]});
            end else begin
                r = pbyte(r, {5'b11110, cp[20:18]});
                r = pbyte(r, {2'b10, cp[17:12]});
                r = pbyte(r, {2'b10, cp[11:6]});
                r = pbyte(r, {2'b10, cp[5:0]});
            end
        end
        r = reset_hex(r);
        r.s.mode = M_STRING;
        return r;
    endfunction

    always_comb begin
        t_work      w;
        t_cls       cls;
        logic [7:0] c;
        logic       one;
        logic       again;
        logic       done;
        logic       is_dig;
        logic       is_alp;
        logic [4:0] v;
        logic [7:0] b0;
        logic [5:0] b1;
        logic [5:0] b2;
        logic [5:0] b3;
        logic [20:0] cp;

        w.s = i_state;
        w.l = '0;
        c   = i_char_bytes[7:0];
        one = (i_byte_count == 3'd1);
        if (i_end) cls = CL_END;
        else if (i_fault || i_byte_count == 3'd0 || i_byte_count > 3'd4) cls = CL_FAULT;
        else cls = CL_CHAR;
        is_dig = (c inside {[8'h30:8'h39]});
        is_alp = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
        v  = one ? hex_value(c) : 5'd16;
        b0 = i_char_bytes[7:0];
        b1 = i_char_bytes[13:8];
        b2 = i_char_bytes[21:16];
        b3 = i_char_bytes[29:24];
        case (i_byte_count)
            3'd1:    cp = {13'd0, b0};
            3'd2:    cp = {10'd0, b0[4:0], b1};
            3'd3:    cp = {5'd0, b0[3:0], b1, b2};
            default: cp = {b0[2:0], b1, b2, b3};
        endcase

        again = 1'b1;
        for (int p = 0; p < 4; p++) begin
            if (again) begin
                again = 1'b0;
                done  = 1'b0;
                case (w.s.mode)
                    M_START: begin
                        if (cls == CL_FAULT) w = perr(w, E_DECODE);
                        else if (cls == CL_END) w = ptok(w, T_EOF);
                        else if (!one) w = perr(w, E_BAD_CHAR);
                        else begin
                            case (c)
                                C_QUOTE: w.s.mode = M_STRING;
                                C_MINUS, C_PLUS: begin
                                    w = clear_number(w);
                                    w.s.sign = {1'b1, c};
                                    if (c == C_PLUS) w = perr(w, E_LEAD_PLUS);
                                    w.s.mode = M_INTEGER;
                                end
                                C_DOT: begin
                                    w = clear_number(w);
                                    w = perr(w, E_LEAD_DOT);
                                    w = pbyte(w, C_DOT);
                                    w.s.nflags[NF_FRAC] = 1'b1;
                                    w.s.mode = M_FRACTION;
                                end
                                C_SPACE, C_TAB, C_CR, C_LF: ;
                                C_LBRACK: w = ptok(w, T_LBRACK);
                                C_RBRACK: w = ptok(w, T_RBRACK);
                                C_COMMA:  w = ptok(w, T_COMMA);
                                C_LBRACE: w = ptok(w, T_LBRACE);
                                C_RBRACE: w = ptok(w, T_RBRACE);
                                C_COLON:  w = ptok(w, T_COLON);
                                default: begin
                                    if (is_dig) begin
                                        w = clear_number(w);
                                        w = pbyte(w, c);
                                        w.s.int_cnt = 2'd1;
                                        if (c == C_ZERO) w.s.nflags[NF_FIRST_ZERO] = 1'b1;
                                        w.s.mode = M_INTEGER;
                                    end else if (is_alp) begin
                                        w = pbyte(w, c);
                                        if (c == C_LC_T) w.s.kw = {KW_TRUE, 3'd1};
                                        else if (c == C_LC_F) w.s.kw = {KW_FALSE, 3'd1};
                                        else if (c == C_LC_N) w.s.kw = {KW_NULL, 3'd1};
                                        else w.s.kw = 5'd0;
                                        w.s.mode = M_WORD;
                                    end else begin
                                        w = perr(w, E_BAD_CHAR);
                                    end
                                end
                            endcase
                        end
                    end
                    M_STRING: begin
                        if (cls == CL_FAULT) w = perr(w, E_DECODE);
                        else if (cls == CL_END) begin
                            w = ptok(w, T_STRING);
                            w.s.mode = M_START;
                            again = 1'b1;
                        end else if (one && c == C_QUOTE) begin
                            w = ptok(w, T_STRING);
                            w.s.mode = M_START;
                        end else if (one && c == C_BSLASH) begin
                            w.s.mode = M_ESCAPE;
                        end else if (cp < CP_MIN) w = perr(w, E_CP_LOW);
                        else if (cp > CP_MAX) w = perr(w, E_CP_HIGH);
                        else begin
                            for (int i = 0; i < 4; i++) begin
                                if (3'(i) < i_byte_count) w = pbyte(w, i_char_bytes[8*i +: 8]);
                            end
                        end
                    end
                    M_ESCAPE: begin
                        w.s.mode = M_STRING;
                        if (cls == CL_FAULT) w = perr(w, E_DECODE);
                        else if (cls == CL_END) begin
                            w = perr(w, E_ESC_MISS);
                            again = 1'b1;
                        end else if (!one) w = perr(w, E_ESC_BAD);
                        else begin
                            case (c)
                                C_BSLASH, C_SLASH, C_QUOTE: w = pbyte(w, c);
                                C_LC_B: w = pbyte(w, C_BS);
                                C_LC_F: w = pbyte(w, C_FF);
                                C_LC_N: w = pbyte(w, C_LF);
                                C_LC_R: w = pbyte(w, C_CR);
                                C_LC_T: w = pbyte(w, C_TAB);
                                C_LC_U: begin
                                    w = reset_hex(w);
                                    w.s.mode = M_UNICODE;
                                end
                                default: w = perr(w, E_ESC_BAD);
                            endcase
                        end
                    end
                    M_UNICODE: begin
                        if (w.s.hex_slot < 3'd4) begin
                            if (cls == CL_END) begin
                                w = perr(w, E_UNI_SHORT);
                                w = reset_hex(w);
                                w.s.mode = M_STRING;
                                again = 1'b1;
                            end else begin
                                if (cls == CL_FAULT) w = perr(w, E_DECODE);
                                else if (!v[4]) w.s.hex_acc = {w.s.hex_acc[19:0], v[3:0]};
                                else begin
                                    w = perr(w, E_HEX_BAD);
                                    w.s.hex_ok = 1'b0;
                                end
                                w.s.hex_slot = w.s.hex_slot + 3'd1;
                            end
                        end else if (cls == CL_FAULT) begin
                            w = perr(w, E_DECODE);
                            w = finish_unicode(w);
                        end else if (cls == CL_END || v[4]) begin
                            w = finish_unicode(w);
                            again = 1'b1;
                        end else begin
                            w.s.hex_acc  = {w.s.hex_acc[19:0], v[3:0]};
                            w.s.hex_slot = w.s.hex_slot + 3'd1;
                            if (w.s.hex_slot >= 3'd6) w = finish_unicode(w);
                        end
                    end
                    M_INTEGER, M_FRACTION, M_EXPONENT: begin
                        if (cls == CL_FAULT) begin
                            w = perr(w, E_DECODE);
                            w = finish_number(w);
                            done = 1'b1;
                        end else if (cls == CL_END) begin
                            done = 1'b0;
                        end else if (w.s.mode == M_INTEGER) begin
                            if (one && is_dig) begin
                                w = flush_sign(w);
                                w = pbyte(w, c);
                                if (w.s.int_cnt == 2'd0 && c == C_ZERO)
                                    w.s.nflags[NF_FIRST_ZERO] = 1'b1;
                                if (w.s.int_cnt < 2'd2) w.s.int_cnt = w.s.int_cnt + 2'd1;
                                done = 1'b1;
                            end else if (one && c == C_DOT) begin
                                w = flush_sign(w);
                                w = pbyte(w, c);
                                w.s.nflags[NF_FRAC] = 1'b1;
                                w.s.mode = M_FRACTION;
                                done = 1'b1;
                            end else if (one && (c == C_LC_E || c == C_UC_E)) begin
                                w = flush_sign(w);
                                w = pbyte(w, c);
                                w.s.nflags[NF_EXP] = 1'b1;
                                w.s.mode = M_EXPONENT;
                                done = 1'b1;
                            end
                        end else if (w.s.mode == M_FRACTION) begin
                            if (one && is_dig) begin
                                w = pbyte(w, c);
                                w.s.nflags[NF_FRAC_DIGIT] = 1'b1;
                                done = 1'b1;
                            end else if (one && (c == C_LC_E || c == C_UC_E)) begin
                                w = pbyte(w, c);
                                w.s.nflags[NF_EXP] = 1'b1;
                                w.s.mode = M_EXPONENT;
                                done = 1'b1;
                            end
                        end else begin
                            if (one && (c == C_PLUS || c == C_MINUS)) begin
                                if (w.s.nflags[NF_EXP_DIGIT]) w = perr(w, E_EXP_SIGNL);
                                else if (w.s.nflags[NF_EXP_SIGN]) w = perr(w, E_EXP_SIGN2);
                                else begin
                                    w = pbyte(w, c);
                                    w.s.nflags[NF_EXP_SIGN] = 1'b1;
                                end
                                done = 1'b1;
                            end else if (one && is_dig) begin
                                w = pbyte(w, c);
                                w.s.nflags[NF_EXP_DIGIT] = 1'b1;
                                done = 1'b1;
                            end
                        end
                        if (!done) begin
                            w = finish_number(w);
                            again = 1'b1;
                        end
                    end
                    M_WORD: begin
                        if (cls == CL_FAULT) begin
                            w = perr(w, E_DECODE);
                            w = finish_word(w);
                        end else if (cls == CL_CHAR && one && is_alp) begin
                            w = pbyte(w, c);
                            if (w.s.kw[4:3] != KW_NONE && w.s.kw[2:0] < kw_len(w.s.kw[4:3])
                                && kw_char(w.s.kw[4:3], w.s.kw[2:0]) == c)
                                w.s.kw = {w.s.kw[4:3], w.s.kw[2:0] + 3'd1};
                            else
                                w.s.kw = 5'd0;
                        end else begin
                            w = finish_word(w);
                            again = 1'b1;
                        end
                    end
                    default: begin
                        w.s.mode = M_START;
                        again = 1'b1;
                    end
                endcase
            end
        end

        o_state = w.s;
        o_list  = w.l;
    end

endmodule
`default_nettype wire

### tb/sv/tb_json_token_lexer.sv
module tb_json_token_lexer;
    timeunit 1ns;
    timeprecision 1ps;

    import jtl_pkg::*;

    // character classes as the lexer sees them
    localparam int CL_CHAR  = 0;
    localparam int CL_END   = 1;
    localparam int CL_FAULT = 2;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 360;

    localparam logic [8*22-1:0] HEX_CHARS = "0123456789abcdefABCDEF";

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value_byte;
        logic [3:0] token_type;
        logic [4:0] error_code;
        logic       last;
    } t_lex_res;

    typedef struct packed {
        logic [31:0] char_bytes;
        logic [2:0]  byte_count;
        logic        end_of_input;
        logic        decode_fault;
        logic        drain;
    } t_char_item;

    logic i_clk;
    logic i_rst_n;

    jtl_in_if  in_if();
    jtl_out_if out_if();

    json_token_lexer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // lexer state mirror
    t_mode       lx_mode;
    logic [23:0] lx_hex;
    logic [2:0]  lx_slot;
    logic        lx_hex_ok;
    logic [1:0]  lx_int_cnt;
    logic [5:0]  lx_nflags;
    logic [8:0]  lx_sign;
    logic [4:0]  lx_kw;

    t_lex_res   step_results[$];
    t_lex_res   pending_results[$];
    t_char_item char_q[$];
    t_char_item cur_char;

    int  error_count = 0;
    int  n_chars_in = 0;
    int  n_results_out = 0;
    int  tx_gap = 0;
    int  rx_wait = 0;
    int  hold_cnt = 0;
    bit  hold_done = 0;
    bit  drain_next = 0;
    int  idle_cycles = 0;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // ---------------------------------------------------------------
    // expected-result generation: lexer mirror
    // ---------------------------------------------------------------

    function automatic void put_res(logic [1:0] k, logic [7:0] vb, logic [3:0] tt,
                                    logic [4:0] ec);
        t_lex_res r;
        r = '{kind: k, value_byte: vb, token_type: tt, error_code: ec, last: 1'b0};
        if (step_results.size() < 8) step_results.push_back(r);
    endfunction

    function automatic void put_byte(logic [7:0] b);
        put_res(K_BYTE, b, 4'd0, 5'd0);
    endfunction

    function automatic void put_tok(logic [3:0] t);
        put_res(K_TOKEN, 8'd0, t, 5'd0);
    endfunction

    function automatic void put_err(logic [4:0] e);
        put_res(K_ERROR, 8'd0, 4'd0, e);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [4:0] hex_of(logic [7:0] c);
        if (is_digit(c)) return 5'(c - "0");
        if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
        if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
        return 5'd16;
    endfunction

    function automatic logic [2:0] word_len(logic [1:0] id);
        case (id)
            KW_TRUE:  return 3'd4;
            KW_FALSE: return 3'd5;
            KW_NULL:  return 3'd4;
            default:  return 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] word_char(logic [1:0] id, logic [2:0] pos);
        logic [39:0] w;
        case (id)
            KW_TRUE:  w = "true";
            KW_FALSE: w = "false";
            default:  w = "null";
        endcase
        return w[(word_len(id) - 1 - pos) * 8 +: 8];
    endfunction

    function automatic void clear_number();
        lx_int_cnt = 2'd0;
        lx_nflags  = 6'd0;
        lx_sign    = 9'd0;
    endfunction

    function automatic void reset_hex();
        lx_hex    = 24'd0;
        lx_slot   = 3'd0;
        lx_hex_ok = 1'b1;
    endfunction

    function automatic void flush_sign();
        if (lx_sign[8]) put_byte(lx_sign[7:0]);
        lx_sign = 9'd0;
    endfunction

    // closing checks of a number run in a fixed order
    function automatic void finish_number();
        if (lx_nflags[NF_EXP] && !lx_nflags[NF_EXP_DIGIT]) put_err(E_EXP_EMPTY);
        if (lx_nflags[NF_FRAC] && !lx_nflags[NF_FRAC_DIGIT]) put_err(E_FRAC_EMPTY);
        if (lx_sign[8]) begin
            put_err(E_LONE_SIGN);
            put_byte(C_ZERO);
        end
        if (lx_int_cnt >= 2'd2 && lx_nflags[NF_FIRST_ZERO]) put_err(E_LEAD_ZERO);
        put_tok(T_NUMBER);
        clear_number();
        lx_mode = M_START;
    endfunction

    function automatic void finish_word();
        logic [1:0] id;
        id = lx_kw[4:3];
        if (id != KW_NONE && lx_kw[2:0] == word_len(id)) begin
            put_tok(T_TRUE + {2'b00, id} - 4'd1);
        end else begin
            put_err(E_BAD_WORD);
            put_tok(T_NULL);
        end
        lx_kw   = 5'd0;
        lx_mode = M_START;
    endfunction

    function automatic void advance_word(logic [7:0] c);
        logic [1:0] id;
        logic [2:0] len;
        id  = lx_kw[4:3];
        len = lx_kw[2:0];
        if (id != KW_NONE && len < word_len(id) && word_char(id, len) == c)
            lx_kw = {id, len + 3'd1};
        else
            lx_kw = 5'd0;
    endfunction

    function automatic void put_utf8(logic [23:0] cp);
        if (cp < 24'h80) begin
            put_byte(cp[7:0]);
        end else if (cp < 24'h800) begin
            put_byte(8'hC0 | 8'(cp >> 6));
            put_byte(8'h80 | 8'(cp & 24'h3F));
        end else if (cp < 24'h10000) begin
            put_byte(8'hE0 | 8'(cp >> 12));
            put_byte(8'h80 | 8'((cp >> 6) & 24'h3F));
            put_byte(8'h80 | 8'(cp & 24'h3F));
        end else begin
            put_byte(8'hF0 | 8'((cp >> 18) & 24'h7));
            put_byte(8'h80 | 8'((cp >> 12) & 24'h3F));
            put_byte(8'h80 | 8'((cp >> 6) & 24'h3F));
            put_byte(8'h80 | 8'(cp & 24'h3F));
        end
    endfunction

    function automatic void finish_unicode();
        if (lx_hex_ok) begin
            if (lx_hex < 24'(CP_MIN)) put_err(E_CP_LOW);
            else if (lx_hex > 24'(CP_MAX)) put_err(E_CP_HIGH);
            else put_utf8(lx_hex);
        end
        reset_hex();
        lx_mode = M_STRING;
    endfunction

    // raw character inside a string: range check on the decoded code point
    function automatic void string_char(logic [31:0] b, logic [2:0] n);
        logic [31:0] cp;
        case (n)
            3'd1:    cp = {24'd0, b[7:0]};
            3'd2:    cp = {21'd0, b[4:0], b[13:8]};
            3'd3:    cp = {16'd0, b[3:0], b[13:8], b[21:16]};
            default: cp = {11'd0, b[2:0], b[13:8], b[21:16], b[29:24]};
        endcase
        if (cp < 32'(CP_MIN)) begin
            put_err(E_CP_LOW);
        end else if (cp > 32'(CP_MAX)) begin
            put_err(E_CP_HIGH);
        end else begin
            for (int i = 0; i < n; i++) put_byte(b[8*i +: 8]);
        end
    endfunction

    function automatic void start_char(logic [7:0] c);
        case (c)
            C_QUOTE: lx_mode = M_STRING;
            C_MINUS, C_PLUS: begin
                clear_number();
                lx_sign = {1'b1, c};
                if (c == C_PLUS) put_err(E_LEAD_PLUS);
                lx_mode = M_INTEGER;
            end
            C_DOT: begin
                clear_number();
                put_err(E_LEAD_DOT);
                put_byte(C_DOT);
                lx_nflags[NF_FRAC] = 1'b1;
                lx_mode = M_FRACTION;
            end
            C_SPACE, C_TAB, C_CR, C_LF: ;
            C_LBRACK: put_tok(T_LBRACK);
            C_RBRACK: put_tok(T_RBRACK);
            C_COMMA:  put_tok(T_COMMA);
            C_LBRACE: put_tok(T_LBRACE);
            C_RBRACE: put_tok(T_RBRACE);
            C_COLON:  put_tok(T_COLON);
            default: begin
                if (is_digit(c)) begin
                    clear_number();
                    put_byte(c);
                    lx_int_cnt = 2'd1;
                    if (c == C_ZERO) lx_nflags[NF_FIRST_ZERO] = 1'b1;
                    lx_mode = M_INTEGER;
                end else if (is_alpha(c)) begin
                    put_byte(c);
                    lx_kw = 5'd0;
                    if (c == C_LC_T) lx_kw = {KW_TRUE, 3'd1};
                    else if (c == C_LC_F) lx_kw = {KW_FALSE, 3'd1};
                    else if (c == C_LC_N) lx_kw = {KW_NULL, 3'd1};
                    lx_mode = M_WORD;
                end else begin
                    put_err(E_BAD_CHAR);
                end
            end
        endcase
    endfunction

    // returns 1 when the character has to be run again in the new mode
    function automatic bit number_char(int cls, logic [7:0] c, bit one);
        if (cls == CL_FAULT) begin
            put_err(E_DECODE);
            finish_number();
            return 1'b0;
        end
        if (cls == CL_END) begin
            finish_number();
            return 1'b1;
        end
        if (lx_mode == M_INTEGER) begin
            if (one && is_digit(c)) begin
                flush_sign();
                put_byte(c);
                if (lx_int_cnt == 2'd0 && c == C_ZERO) lx_nflags[NF_FIRST_ZERO] = 1'b1;
                if (lx_int_cnt < 2'd2) lx_int_cnt++;
                return 1'b0;
            end
            if (one && c == C_DOT) begin
                flush_sign();
                put_byte(c);
                lx_nflags[NF_FRAC] = 1'b1;
                lx_mode = M_FRACTION;
                return 1'b0;
            end
            if (one && (c == C_LC_E || c == C_UC_E)) begin
                flush_sign();
                put_byte(c);
                lx_nflags[NF_EXP] = 1'b1;
                lx_mode = M_EXPONENT;
                return 1'b0;
            end
        end else if (lx_mode == M_FRACTION) begin
            if (one && is_digit(c)) begin
                put_byte(c);
                lx_nflags[NF_FRAC_DIGIT] = 1'b1;
                return 1'b0;
            end
            if (one && (c == C_LC_E || c == C_UC_E)) begin
                put_byte(c);
                lx_nflags[NF_EXP] = 1'b1;
                lx_mode = M_EXPONENT;
                return 1'b0;
            end
        end else begin
            if (one && (c == C_PLUS || c == C_MINUS)) begin
                if (lx_nflags[NF_EXP_DIGIT]) begin
                    put_err(E_EXP_SIGNL);
                end else if (lx_nflags[NF_EXP_SIGN]) begin
                    put_err(E_EXP_SIGN2);
                end else begin
                    put_byte(c);
                    lx_nflags[NF_EXP_SIGN] = 1'b1;
                end
                return 1'b0;
            end
            if (one && is_digit(c)) begin
                put_byte(c);
                lx_nflags[NF_EXP_DIGIT] = 1'b1;
                return 1'b0;
            end
        end
        finish_number();
        return 1'b1;
    endfunction

    function automatic bit lex_char(int cls, logic [31:0] b, logic [2:0] n);
        logic [7:0] c;
        bit         one;
        logic [4:0] v;
        c   = b[7:0];
        one = (n == 3'd1);
        case (lx_mode)
            M_START: begin
                if (cls == CL_FAULT) put_err(E_DECODE);
                else if (cls == CL_END) put_tok(T_EOF);
                else if (!one) put_err(E_BAD_CHAR);
                else start_char(c);
                return 1'b0;
            end
            M_STRING: begin
                if (cls == CL_FAULT) begin
                    put_err(E_DECODE);
                    return 1'b0;
                end
                if (cls == CL_END) begin
                    put_tok(T_STRING);
                    lx_mode = M_START;
                    return 1'b1;
                end
                if (one && c == C_QUOTE) begin
                    put_tok(T_STRING);
                    lx_mode = M_START;
                    return 1'b0;
                end
                if (one && c == C_BSLASH) begin
                    lx_mode = M_ESCAPE;
                    return 1'b0;
                end
                string_char(b, n);
                return 1'b0;
            end
            M_ESCAPE: begin
                lx_mode = M_STRING;
                if (cls == CL_FAULT) begin
                    put_err(E_DECODE);
                    return 1'b0;
                end
                if (cls == CL_END) begin
                    put_err(E_ESC_MISS);
                    return 1'b1;
                end
                if (!one) begin
                    put_err(E_ESC_BAD);
                    return 1'b0;
                end
                case (c)
                    C_BSLASH, C_SLASH, C_QUOTE: put_byte(c);
                    C_LC_B: put_byte(C_BS);
                    C_LC_F: put_byte(C_FF);
                    C_LC_N: put_byte(C_LF);
                    C_LC_R: put_byte(C_CR);
                    C_LC_T: put_byte(C_TAB);
                    C_LC_U: begin
                        reset_hex();
                        lx_mode = M_UNICODE;
                    end
                    default: put_err(E_ESC_BAD);
                endcase
                return 1'b0;
            end
            M_UNICODE: begin
                v = one ? hex_of(c) : 5'd16;
                // four required digit slots, a fault or bad digit still uses one up
                if (lx_slot < 3'd4) begin
                    if (cls == CL_END) begin
                        put_err(E_UNI_SHORT);
                        reset_hex();
                        lx_mode = M_STRING;
                        return 1'b1;
                    end
                    if (cls == CL_FAULT) begin
                        put_err(E_DECODE);
                    end else if (v < 5'd16) begin
                        lx_hex = {lx_hex[19:0], v[3:0]};
                    end else begin
                        put_err(E_HEX_BAD);
                        lx_hex_ok = 1'b0;
                    end
                    lx_slot++;
                    return 1'b0;
                end
                if (cls == CL_FAULT) begin
                    put_err(E_DECODE);
                    finish_unicode();
                    return 1'b0;
                end
                if (cls == CL_END || v >= 5'd16) begin
                    finish_unicode();
                    return 1'b1;
                end
                lx_hex = {lx_hex[19:0], v[3:0]};
                lx_slot++;
                if (lx_slot >= 3'd6) finish_unicode();
                return 1'b0;
            end
            M_INTEGER, M_FRACTION, M_EXPONENT: return number_char(cls, c, one);
            default: begin
                if (cls == CL_FAULT) begin
                    put_err(E_DECODE);
                    finish_word();
                    return 1'b0;
                end
                if (cls == CL_CHAR && one && is_alpha(c)) begin
                    put_byte(c);
                    advance_word(c);
                    return 1'b0;
                end
                finish_word();
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void predict_char(t_char_item it);
        int cls;
        t_lex_res r;
        if (it.end_of_input) cls = CL_END;
        else if (it.decode_fault || it.byte_count < 3'd1 || it.byte_count > 3'd4) cls = CL_FAULT;
        else cls = CL_CHAR;
        step_results.delete();
        for (int i = 0; i < 4; i++) begin
            if (!lex_char(cls, it.char_bytes, it.byte_count)) break;
        end
        for (int i = 0; i < step_results.size(); i++) begin
            r = step_results[i];
            r.last = (i == step_results.size() - 1);
            pending_results.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    function automatic void push_char(logic [31:0] b, logic [2:0] n, bit eoi, bit flt);
        t_char_item it;
        it = '{char_bytes: b, byte_count: n, end_of_input: eoi, decode_fault: flt,
               drain: drain_next};
        drain_next = 0;
        char_q.push_back(it);
    endfunction

    // ascii character with random junk in the unused upper bytes
    function automatic void push_ascii(logic [7:0] c);
        logic [31:0] junk;
        junk = $urandom;
        push_char({junk[31:8], c}, 3'd1, 1'b0, 1'b0);
    endfunction

    function automatic void push_end();
        push_char($urandom, 3'($urandom_range(0, 7)), 1'b1, 1'($urandom_range(0, 1)));
    endfunction

    function automatic void push_fault();
        push_char($urandom, 3'($urandom_range(1, 4)), 1'b0, 1'b1);
    endfunction

    function automatic logic [7:0] rand_hex_char();
        return HEX_CHARS[(21 - $urandom_range(0, 21)) * 8 +: 8];
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic void gen_string();
        int len;
        int k;
        logic [7:0] esc_set [9];
        esc_set = '{C_QUOTE, C_BSLASH, C_SLASH, C_LC_B, C_LC_F, C_LC_N, C_LC_R, C_LC_T, "q"};
        push_ascii(C_QUOTE);
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: push_ascii(8'($urandom_range(8'h20, 8'h7E)));
                3: begin
                    push_ascii(C_BSLASH);
                    push_ascii(esc_set[$urandom_range(0, 8)]);
                end
                4: begin
                    // unicode escape, four to six digit slots, zeros favored, some bad or faulted
                    push_ascii(C_BSLASH);
                    push_ascii(C_LC_U);
                    k = $urandom_range(4, 6);
                    for (int j = 0; j < k; j++) begin
                        case ($urandom_range(0, 11))
                            0, 1, 2: push_ascii(C_ZERO);
                            3: push_ascii("g");
                            4: if ($urandom_range(0, 2) == 0) push_fault();
                               else push_ascii(rand_hex_char());
                            default: push_ascii(rand_hex_char());
                        endcase
                    end
                end
                5, 6: push_char($urandom, 3'($urandom_range(2, 4)), 1'b0, 1'b0);
                7: push_ascii(8'($urandom_range(0, 8'h1F)));
                8: push_ascii(8'($urandom_range(8'h80, 8'hFF)));
                default: begin
                    if ($urandom_range(0, 1)) push_fault();
                    else push_char($urandom, 3'd1, 1'b0, 1'b0);
                end
            endcase
        end
        if ($urandom_range(0, 7) != 0) push_ascii(C_QUOTE);
    endfunction

    function automatic void gen_number();
        int k;
        case ($urandom_range(0, 7))
            0, 1: push_ascii(C_MINUS);
            2: push_ascii(C_PLUS);
            3: push_ascii(C_DOT);
            default: ;
        endcase
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++) push_ascii(($urandom_range(0, 3) == 0) ? C_ZERO : rand_digit());
        if ($urandom_range(0, 2) == 0) begin
            push_ascii(C_DOT);
            k = $urandom_range(0, 3);
            for (int i = 0; i < k; i++) push_ascii(rand_digit());
        end
        if ($urandom_range(0, 2) == 0) begin
            push_ascii($urandom_range(0, 1) ? C_LC_E : C_UC_E);
            k = $urandom_range(0, 2);
            for (int i = 0; i < k; i++) push_ascii($urandom_range(0, 1) ? C_PLUS : C_MINUS);
            k = $urandom_range(0, 3);
            for (int i = 0; i < k; i++) push_ascii(rand_digit());
            if ($urandom_range(0, 3) == 0) push_ascii(C_MINUS);
        end
        if ($urandom_range(0, 9) == 0) push_fault();
    endfunction

    function automatic void gen_word();
        logic [39:0] w;
        int len;
        case ($urandom_range(0, 4))
            0: begin w = "true";  len = 4; end
            1: begin w = "false"; len = 5; end
            2: begin w = "null";  len = 4; end
            default: begin
                // mangled or unknown word
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(0, 3))
                        0: w[i*8 +: 8] = "n";
                        1: w[i*8 +: 8] = "u";
                        2: w[i*8 +: 8] = 8'("A" + $urandom_range(0, 25));
                        default: w[i*8 +: 8] = 8'("a" + $urandom_range(0, 25));
                    endcase
                end
            end
        endcase
        for (int i = len - 1; i >= 0; i--) push_ascii(w[i*8 +: 8]);
        if ($urandom_range(0, 9) == 0) push_fault();
    endfunction

    function automatic void gen_punct();
        logic [7:0] p [10];
        p = '{C_LBRACK, C_RBRACK, C_COMMA, C_LBRACE, C_RBRACE, C_COLON,
              C_SPACE, C_TAB, C_CR, C_LF};
        push_ascii(p[$urandom_range(0, 9)]);
    endfunction

    function automatic void gen_noise();
        case ($urandom_range(0, 5))
            0: push_end();
            1: push_fault();
            2: push_char($urandom, 3'($urandom_range(0, 7)), 1'b0, 1'b0);
            3: push_char($urandom, 3'($urandom_range(0, 7)), 1'b0, 1'($urandom_range(0, 1)));
            default: push_ascii(8'($urandom));
        endcase
    endfunction

    function automatic void build_stimulus();
        int target;
        bit drain_set;
        // directed: tokens, faults, bad counts, lone sign, leading period,
        // end inside escape and string, bad word, leading zero
        drain_set = 0;
        push_end();
        push_fault();
        push_char($urandom, 3'd0, 1'b0, 1'b0);
        push_char($urandom, 3'd7, 1'b0, 1'b0);
        push_ascii(C_LBRACK);
        push_ascii(C_RBRACK);
        push_ascii(C_COMMA);
        push_ascii(C_LBRACE);
        push_ascii(C_RBRACE);
        push_ascii(C_COLON);
        push_char(32'hFFFF_A9C2, 3'd2, 1'b0, 1'b0);
        push_ascii(C_PLUS);
        push_char(32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1);
        push_ascii(C_DOT);
        push_end();
        push_ascii(C_QUOTE);
        push_ascii(C_BSLASH);
        push_end();
        push_ascii(C_QUOTE);
        push_ascii(8'hFF);
        push_end();
        push_ascii(C_LC_T);
        push_ascii(C_LC_R);
        push_ascii("x");
        push_ascii(C_ZERO);
        push_ascii(C_ZERO);
        push_ascii(C_SPACE);

        target = char_q.size() + RANDOM_ITEMS;
        while (char_q.size() < target) begin
            // one pause for a full drain partway through
            if (!drain_set && char_q.size() >= target - RANDOM_ITEMS / 2) begin
                drain_next = 1;
                drain_set  = 1;
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: gen_string();
                6, 7, 8, 9, 10: gen_number();
                11, 12, 13: gen_word();
                14, 15, 16: gen_punct();
                default: gen_noise();
            endcase
        end
        push_end();
    endfunction

    // ---------------------------------------------------------------
    // reset and sequence
    // ---------------------------------------------------------------

    initial begin
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.char_bytes    = 32'd0;
        in_if.byte_count    = 3'd1;
        in_if.end_of_input  = 1'b0;
        in_if.decode_fault  = 1'b0;
        out_if.ready        = 1'b0;
        lx_mode = M_START;
        reset_hex();
        clear_number();
        lx_kw = 5'd0;
        build_stimulus();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // wait for the stream to go out and every result to come back
        do @(posedge i_clk);
        while (char_q.size() != 0 || in_if.valid || pending_results.size() != 0);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // character driver
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        logic nv;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            nv = in_if.valid;
            if (in_if.valid && in_if.ready) begin
                predict_char(cur_char);
                n_chars_in++;
                nv = 1'b0;
                // stretches with no gaps between transfers
                tx_gap = ((n_chars_in / 40) % 4 == 0) ? 0 : $urandom_range(0, 12);
            end else if (!in_if.valid && tx_gap > 0) begin
                tx_gap--;
            end
            if (!nv && tx_gap == 0 && char_q.size() != 0 &&
                !(char_q[0].drain && pending_results.size() != 0)) begin
                cur_char = char_q.pop_front();
                in_if.char_bytes   <= cur_char.char_bytes;
                in_if.byte_count   <= cur_char.byte_count;
                in_if.end_of_input <= cur_char.end_of_input;
                in_if.decode_fault <= cur_char.decode_fault;
                nv = 1'b1;
            end
            in_if.valid <= nv;
        end
    end

    // ---------------------------------------------------------------
    // result monitor and checker
    // ---------------------------------------------------------------

    task automatic report(string what, int exp_v, int got_v);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_lex_res want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (pending_results.size() == 0) begin
                    report("result with nothing pending, kind", -1, out_if.kind);
                end else begin
                    want = pending_results.pop_front();
                    if (out_if.kind !== want.kind) report("kind", want.kind, out_if.kind);
                    if (out_if.value_byte !== want.value_byte)
                        report("value_byte", want.value_byte, out_if.value_byte);
                    if (out_if.token_type !== want.token_type)
                        report("token_type", want.token_type, out_if.token_type);
                    if (out_if.error_code !== want.error_code)
                        report("error_code", want.error_code, out_if.error_code);
                    if (out_if.last !== want.last) report("last", want.last, out_if.last);
                end
                n_results_out++;
                rx_wait = ((n_results_out / 50) % 4 == 1) ? 0 : $urandom_range(0, 12);
            end
            // one long hold-off while the driver keeps offering characters
            if (!hold_done && n_chars_in >= 150) begin
                hold_done = 1;
                hold_cnt  = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_if.ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule

### files.f
rtl/core/jtl_pkg.sv
rtl/core/jtl_ifs.sv
rtl/core/jtl_step.sv
rtl/core/json_token_lexer.sv
tb/sv/tb_json_token_lexer.sv
